[hw/rtl/ed_pkg.sv]
// ed_pkg: shared types, command codes and small helpers for the edit distance block.
// No dependencies.
package ed_pkg;

  localparam int CHAR_W = 8;
  localparam int DIST_W = 8;
  localparam int CMD_W  = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [DIST_W-1:0] dist_t;

  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_CAND   = 2'd1;
  localparam cmd_t CMD_END    = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  localparam dist_t DIST_MAX = 8'hFF;
  localparam dist_t CLOSE_THR_RESET = 8'd2;

  function automatic dist_t sat_inc(input dist_t v);
    return (v == DIST_MAX) ? DIST_MAX : v + 8'd1;
  endfunction

  function automatic dist_t min3(input dist_t a, input dist_t b, input dist_t c);
    dist_t m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

endpackage

[hw/rtl/ed_ram.sv]
// ed_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/edit_distance.sv]
// edit_distance: Levenshtein distance of a streamed candidate against a stored reference.
// Uses ed_pkg and two ed_ram instances (reference bytes, DP row cells 1..N).
// Throughput: append and clear are taken while idle; a candidate byte with a non-empty reference
// runs one DP cell per cycle through the shared min/compare unit and the row RAM port, with s_tready
// low until its last cell is written; end passes S_ENDR and S_ENDW (which waits for a free output
// register) to the output register, and the result then waits for m_tready.
// Reset (rst, synchronous): empty reference, row k = k, threshold 2, no result pending.
module edit_distance
  import ed_pkg::*;
#(
  parameter int MAX_REF_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] char_code
  input  logic [1:0]  s_tuser,      // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // [7:0] distance, [8] is_close, [9] overflow, zero fill
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int REF_AW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_REF_LEN + 1);
  localparam int IW     = (LEN_W > 8) ? LEN_W : 9;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_REF_LEN);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_ENDR = 2'd2;
  localparam logic [1:0] S_ENDW = 2'd3;

  function automatic dist_t init_cell(input logic [LEN_W-1:0] k);
    logic [IW-1:0] kx;
    kx = IW'(k);
    return (kx > IW'(255)) ? DIST_MAX : kx[7:0];
  endfunction

  logic [1:0]             state;
  logic [LEN_W-1:0]       ref_len;
  logic                   ovf;
  dist_t                  cand_len;
  dist_t                  thr;
  logic [MAX_REF_LEN-1:0] row_valid;
  logic [REF_AW-1:0]      ptr;
  logic                   iss;
  logic                   pend;
  logic [REF_AW-1:0]      paddr;
  dist_t                  diag;
  dist_t                  left;
  char_t                  cur_char;
  logic                   row_v_q;
  dist_t                  out_dist;
  logic                   out_close;
  logic                   out_ovf;

  logic              in_fire;
  cmd_t              cmd;
  logic [LEN_W-1:0]  len_m1;
  logic              ref_we;
  logic [REF_AW-1:0] row_raddr;
  char_t             ref_rdata;
  dist_t             row_rdata;
  dist_t             up;
  dist_t             cell_val;
  dist_t             end_dist;
  logic              out_free;
  logic              last_issue;

  assign s_tready   = (state == S_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign cmd        = s_tuser;
  assign len_m1     = ref_len - LEN_W'(1);
  assign ref_we     = in_fire && (cmd == CMD_APPEND) && (ref_len < LEN_MAX);
  assign row_raddr  = (state == S_RUN) ? ptr : len_m1[REF_AW-1:0];
  assign last_issue = (LEN_W'(ptr) == len_m1);
  assign out_free   = !m_tvalid || m_tready;

  assign up       = row_v_q ? row_rdata : init_cell(LEN_W'(paddr) + LEN_W'(1));
  assign cell_val = (ref_rdata == cur_char) ? diag : sat_inc(min3(diag, up, left));
  assign end_dist = (ref_len == '0) ? cand_len :
                    (row_v_q ? row_rdata : init_cell(ref_len));

  assign m_tdata = {6'd0, out_ovf, out_close, out_dist};

  ed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_REF_LEN)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_len[REF_AW-1:0]),
    .wdata (s_tdata),
    .raddr (ptr),
    .rdata (ref_rdata)
  );

  ed_ram #(.WIDTH(DIST_W), .DEPTH(MAX_REF_LEN)) u_row_ram (
    .clk   (clk),
    .we    (pend),
    .waddr (paddr),
    .wdata (cell_val),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    row_v_q <= row_valid[row_raddr];
    if (in_fire && (cmd == CMD_CAND)) begin
      cur_char <= s_tdata;
      diag     <= cand_len;
      left     <= sat_inc(cand_len);
    end else if (pend) begin
      diag <= up;
      left <= cell_val;
    end
    if (state == S_ENDW && out_free) begin
      out_dist  <= end_dist;
      out_close <= (end_dist < thr);
      out_ovf   <= ovf;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ref_len   <= '0;
      ovf       <= 1'b0;
      cand_len  <= '0;
      thr       <= CLOSE_THR_RESET;
      row_valid <= '0;
      ptr       <= '0;
      iss       <= 1'b0;
      pend      <= 1'b0;
      paddr     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (cmd)
              CMD_APPEND: begin
                if (ref_len < LEN_MAX) begin
                  ref_len <= ref_len + LEN_W'(1);
                end else begin
                  ovf <= 1'b1;
                end
                row_valid <= '0;
                cand_len  <= '0;
              end
              CMD_CAND: begin
                cand_len <= sat_inc(cand_len);
                if (ref_len != '0) begin
                  state <= S_RUN;
                  ptr   <= '0;
                  iss   <= 1'b1;
                end
              end
              CMD_END: begin
                state <= S_ENDR;
              end
              default: begin
                ref_len   <= '0;
                ovf       <= 1'b0;
                row_valid <= '0;
                cand_len  <= '0;
              end
            endcase
          end
        end
        S_RUN: begin
          // issue read of cell ptr; the cell read last cycle is computed and written
          pend  <= iss;
          paddr <= ptr;
          if (iss) begin
            if (last_issue) begin
              iss <= 1'b0;
            end else begin
              ptr <= ptr + REF_AW'(1);
            end
          end
          if (pend) begin
            row_valid[paddr] <= 1'b1;
            if (LEN_W'(paddr) == len_m1) begin
              state <= S_IDLE;
              pend  <= 1'b0;
            end
          end
        end
        S_ENDR: begin
          state <= S_ENDW;
        end
        S_ENDW: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            row_valid <= '0;
            cand_len  <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/ed_checker.sv]
// ed_checker: port-level assertions for edit_distance, attached by bind.
// Uses ed_pkg.
module ed_checker
  import ed_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        cfg_wr_en,
  input logic [7:0]  cfg_wr_data
);

  dist_t thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= CLOSE_THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_close_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] == (m_tdata[7:0] < thr)) && (m_tdata[15:10] == 6'd0))
    else $error("close flag or fill bits wrong");

  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_END) |=> !s_tready)
    else $error("ready during end transaction");

endmodule

bind edit_distance ed_checker u_ed_checker (
  .clk         (clk),
  .rst         (rst),
  .s_tvalid    (s_tvalid),
  .s_tready    (s_tready),
  .s_tuser     (s_tuser),
  .m_tvalid    (m_tvalid),
  .m_tready    (m_tready),
  .m_tdata     (m_tdata),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

[tb/edit_distance_tb.sv]
// edit_distance_tb: self-checking testbench for edit_distance (Levenshtein distance block).
// Drives reference/candidate byte streams with random idling, predicts each distance
// report in a local DP row model and compares every result transaction. Uses ed_pkg.
`timescale 1ns / 1ps

module edit_distance_tb;
  import ed_pkg::*;

  localparam int REF_CAP      = 32;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    dist_t distance;
    logic  is_close;
    logic  overflow;
  } dist_report_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_code
  logic [1:0]  s_tuser;   // [1:0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [7:0] distance, [8] is_close, [9] overflow, zero fill
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  // local copy of the block state
  char_t ref_bytes [REF_CAP];
  int    ref_len;
  dist_t score_cells [REF_CAP+1];
  dist_t cand_len;
  logic  ref_dropped;
  dist_t close_thr;

  dist_report_t expected_reports[$];
  int errors;
  int items_sent;
  int cycle_count;
  int tx_level;
  int rx_level;
  int hold_req;
  int alpha_n;

  edit_distance #(.MAX_REF_LEN(REF_CAP)) dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic dist_t bump_capped(input dist_t v);
    return (v == DIST_MAX) ? v : v + 8'd1;
  endfunction

  function automatic int draw_wait(input int level);
    case (level)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic char_t rand_char();
    if (alpha_n == 0) return char_t'($urandom_range(0, 255));
    return char_t'(8'h61 + $urandom_range(0, alpha_n - 1));
  endfunction

  task automatic restart_cells();
    int k;
    for (k = 0; k <= REF_CAP; k++) score_cells[k] = dist_t'(k);
    cand_len = '0;
  endtask

  task automatic advance_cells(input char_t ch);
    dist_t diag, up, lo;
    int k;
    diag = score_cells[0];
    cand_len = bump_capped(cand_len);
    score_cells[0] = cand_len;
    for (k = 1; k <= ref_len; k++) begin
      up = score_cells[k];
      lo = diag;
      if (ref_bytes[k-1] != ch) begin
        if (up < lo) lo = up;
        if (score_cells[k-1] < lo) lo = score_cells[k-1];
        lo = bump_capped(lo);
      end
      diag = up;
      score_cells[k] = lo;
    end
  endtask

  task automatic update_distance_model(input cmd_t cmd, input char_t ch);
    dist_report_t rep;
    case (cmd)
      CMD_APPEND: begin
        if (ref_len < REF_CAP) begin
          ref_bytes[ref_len] = ch;
          ref_len++;
        end else begin
          ref_dropped = 1'b1;
        end
        restart_cells();
      end
      CMD_CAND: advance_cells(ch);
      CMD_END: begin
        rep.distance = score_cells[ref_len];
        rep.is_close = (rep.distance < close_thr);
        rep.overflow = ref_dropped;
        expected_reports.push_back(rep);
        restart_cells();
      end
      default: begin
        ref_len = 0;
        ref_dropped = 1'b0;
        restart_cells();
      end
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    dist_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result transaction, m_tdata=%h", m_tdata);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (m_tdata[7:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[8] !== want.is_close) begin
          $error("is_close: expected %0d, got %0d", want.is_close, m_tdata[8]);
          errors++;
        end
        if (m_tdata[9] !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, m_tdata[9]);
          errors++;
        end
      end
    end
  end

  // result receiver: random stall before each transaction, long hold-off on request
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end else begin
        stall = draw_wait(rx_level);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_item(input cmd_t cmd, input char_t ch);
    int gap;
    gap = draw_wait(tx_level);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    update_distance_model(cmd, ch);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input cmd_t cmd, input string w);
    int i;
    for (i = 0; i < w.len(); i++) send_item(cmd, char_t'(w[i]));
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input dist_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    close_thr = v;
  endtask

  task automatic test_directed();
    tx_level = 1;
    rx_level = 1;
    send_item(CMD_END, 8'h00);          // empty reference, empty candidate
    send_item(CMD_APPEND, 8'h00);
    send_item(CMD_APPEND, 8'hFF);
    send_item(CMD_CAND, 8'hFF);
    send_item(CMD_CAND, 8'h00);
    send_item(CMD_END, 8'hFF);
    send_item(CMD_CAND, 8'h00);
    send_item(CMD_APPEND, 8'h7F);       // append restarts the candidate
    send_item(CMD_END, 8'h00);          // empty candidate
    send_item(CMD_CLEAR, 8'hAA);
    send_item(CMD_CAND, 8'h61);
    send_item(CMD_CAND, 8'h62);
    send_item(CMD_END, 8'h55);          // empty reference
    send_word(CMD_APPEND, "kitten");
    send_word(CMD_CAND, "sitting");
    send_item(CMD_END, 8'h00);
  endtask

  task automatic test_reference_overflow();
    int i;
    wait_results_done();
    write_threshold(8'd40);
    send_item(CMD_CLEAR, 8'h00);
    for (i = 0; i < REF_CAP + 2; i++) send_item(CMD_APPEND, char_t'($urandom_range(0, 255)));
    send_item(CMD_END, 8'h00);
    send_item(CMD_CAND, 8'h41);
    send_item(CMD_END, 8'h00);
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_END, 8'h00);
  endtask

  task automatic test_long_candidate();
    int i;
    wait_results_done();
    write_threshold(DIST_MAX);
    tx_level = 0;
    send_item(CMD_CLEAR, 8'h00);
    send_word(CMD_APPEND, "xyz");
    for (i = 0; i < 262; i++) send_item(CMD_CAND, char_t'(8'h70 + $urandom_range(0, 15)));
    send_item(CMD_END, 8'h00);
  endtask

  task automatic test_backpressure();
    int i;
    wait_results_done();
    tx_level = 0;
    rx_level = 0;
    hold_req = 600;
    send_item(CMD_CLEAR, 8'h00);
    send_word(CMD_APPEND, "abcd");
    for (i = 0; i < 14; i++) begin
      send_item(CMD_CAND, char_t'(8'h61 + $urandom_range(0, 4)));
      send_item(CMD_CAND, char_t'(8'h61 + $urandom_range(0, 4)));
      send_item(CMD_END, 8'h00);
      send_item(CMD_END, 8'h00);
    end
    wait_results_done();                // sender pauses until everything is back
    send_word(CMD_CAND, "abd");
    send_item(CMD_END, 8'h00);
  endtask

  task automatic send_candidate();
    int k, op, n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, 10);
      repeat (n) send_item(CMD_CAND, rand_char());
    end else begin
      for (k = 0; k < ref_len; k++) begin
        op = $urandom_range(0, 11);
        if (op == 1) begin
          send_item(CMD_CAND, rand_char());
        end else if (op != 0) begin
          if (op == 2) send_item(CMD_CAND, rand_char());
          send_item(CMD_CAND, ref_bytes[k]);
        end
      end
    end
    if ($urandom_range(0, 15) != 0) send_item(CMD_END, rand_char());
  endtask

  task automatic run_word_rounds(input int n_items);
    int stop_at, len, i;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) tx_level = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) rx_level = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_item(cmd_t'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)));
      end else begin
        alpha_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 5);
        if ($urandom_range(0, 3) != 0) send_item(CMD_CLEAR, rand_char());
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 8);
        for (i = 0; i < len; i++) send_item(CMD_APPEND, rand_char());
        repeat ($urandom_range(1, 4)) send_candidate();
      end
    end
  endtask

  task automatic test_threshold_phases();
    dist_t thr_list [5];
    int p;
    thr_list[0] = 8'd0;
    thr_list[1] = DIST_MAX;
    thr_list[2] = 8'd1;
    thr_list[3] = dist_t'($urandom_range(3, 254));
    thr_list[4] = CLOSE_THR_RESET;
    for (p = 0; p < 5; p++) begin
      wait_results_done();
      write_threshold(thr_list[p]);
      run_word_rounds(280);
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = CMD_APPEND;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    errors      = 0;
    items_sent  = 0;
    cycle_count = 0;
    tx_level    = 0;
    rx_level    = 0;
    hold_req    = 0;
    alpha_n     = 0;
    ref_len     = 0;
    ref_dropped = 1'b0;
    close_thr   = CLOSE_THR_RESET;
    restart_cells();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_reference_overflow();
    test_long_candidate();
    test_backpressure();
    test_threshold_phases();

    wait_results_done();
    if (expected_reports.size() != 0) begin
      $error("%0d distance reports never arrived", expected_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
